[rtl/core/akd_pkg.sv]
`timescale 1ns / 1ps

package akd_pkg;

	typedef struct packed {
		logic       op;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [4:0] key_code;
		logic [7:0] char_value;
	} out_item_t;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_ESC   = 8'b0000_0010,
		PH_CSI   = 8'b0000_0100,
		PH_SS3   = 8'b0000_1000,
		PH_ONE   = 8'b0001_0000,
		PH_SEMI  = 8'b0010_0000,
		PH_MOD   = 8'b0100_0000,
		PH_DIGIT = 8'b1000_0000
	} phase_t;

	localparam logic       OP_BYTE = 1'b0;
	localparam logic       OP_TICK = 1'b1;

	localparam logic [0:0] REG_GAP_TICKS = 1'b0;
	localparam logic [15:0] GAP_TICKS_RESET = 16'd50;

	localparam logic [4:0] KC_CHAR  = 5'd0;
	localparam logic [4:0] KC_ESC   = 5'd1;
	localparam logic [4:0] KC_UP    = 5'd2;
	localparam logic [4:0] KC_DN    = 5'd3;
	localparam logic [4:0] KC_LT    = 5'd4;
	localparam logic [4:0] KC_RT    = 5'd5;
	localparam logic [4:0] KC_HM    = 5'd6;
	localparam logic [4:0] KC_END   = 5'd7;
	localparam logic [4:0] KC_PAGEU = 5'd8;
	localparam logic [4:0] KC_PAGED = 5'd9;
	localparam logic [4:0] KC_INS   = 5'd10;
	localparam logic [4:0] KC_DEL   = 5'd11;
	localparam logic [4:0] KC_CHOME = 5'd12;
	localparam logic [4:0] KC_CEND  = 5'd13;
	localparam logic [4:0] KC_F1    = 5'd14;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_CSI  = 8'h5B;
	localparam logic [7:0] CH_SS3  = 8'h4F;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_1    = 8'h31;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_8    = 8'h38;
	localparam logic [7:0] CH_A    = 8'h41;
	localparam logic [7:0] CH_B    = 8'h42;
	localparam logic [7:0] CH_C    = 8'h43;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_F    = 8'h46;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_Q    = 8'h51;
	localparam logic [7:0] CH_R    = 8'h52;
	localparam logic [7:0] CH_S    = 8'h53;

	function automatic logic [4:0] digit_key(input logic [2:0] idx);
		logic [4:0] k;
		case (idx)
			3'd0:    k = KC_INS;
			3'd1:    k = KC_DEL;
			3'd2:    k = KC_END;
			3'd3:    k = KC_PAGEU;
			3'd4:    k = KC_PAGED;
			3'd5:    k = KC_HM;
			3'd6:    k = KC_END;
			default: k = KC_INS;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/ansi_key_escape_decoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_stall    in_data (op, byte_value)
// out       output     out_valid / out_stall  out_data (key_code, char_value)
// config    input      APB write/read         gap_ticks at byte address 0
//
// One transfer is accepted per cycle; the parser state updates in that cycle and
// a key event is registered into the output register, or into the skid entry while that register is stalled.
// A two-entry output buffer (output register plus skid entry) sets the rate: input
// stalls only while both entries are occupied. Reset clears the parser to idle,
// empties the output buffer, and sets gap_ticks to 50.

module ansi_key_escape_decoder
	import akd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        accept;
	logic        buf_full;
	logic        res_valid;
	out_item_t   res;
	logic [15:0] gap_ticks;

	assign in_stall = buf_full;
	assign accept   = in_valid & ~buf_full;

	akd_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.gap_ticks (gap_ticks)
	);

	akd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.gap_ticks (gap_ticks),
		.res_valid (res_valid),
		.res       (res)
	);

	akd_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.full      (buf_full)
	);

endmodule

[rtl/core/akd_apb.sv]
`timescale 1ns / 1ps

module akd_apb
	import akd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] gap_ticks
);

	logic [15:0] gap_ticks_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_GAP_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q <= GAP_TICKS_RESET;
		end else if (wr_en) begin
			gap_ticks_q <= pwdata[15:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GAP_TICKS) begin
			prdata = {16'd0, gap_ticks_q};
		end
	end

	assign gap_ticks = gap_ticks_q;

endmodule

[rtl/core/akd_decode.sv]
`timescale 1ns / 1ps

module akd_decode
	import akd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  in_item_t    item,
	input  logic [15:0] gap_ticks,
	output logic        res_valid,
	output out_item_t   res
);

	phase_t      phase_q, phase_d;
	logic [4:0]  pend_q, pend_d;
	logic [15:0] cnt_q, cnt_d, cnt_inc;
	logic        do_emit, do_wait;
	logic [4:0]  emit_key, wait_key;
	logic [7:0]  emit_char;
	phase_t      wait_ph;
	logic [7:0]  b;

	assign b       = item.byte_value;
	assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;

	always_comb begin
		do_emit   = 1'b0;
		do_wait   = 1'b0;
		emit_key  = KC_ESC;
		emit_char = 8'd0;
		wait_key  = KC_ESC;
		wait_ph   = PH_IDLE;
		phase_d   = phase_q;
		pend_d    = pend_q;
		cnt_d     = cnt_q;

		if (accept) begin
			if (item.op == OP_TICK) begin
				if (phase_q != PH_IDLE) begin
					cnt_d = cnt_inc;
					if (cnt_inc >= gap_ticks) begin
						do_emit  = 1'b1;
						emit_key = pend_q;
					end
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (b == CH_ESC) begin
							do_wait = 1'b1;
							wait_ph = PH_ESC;
						end else begin
							do_emit   = 1'b1;
							emit_key  = KC_CHAR;
							emit_char = b;
						end
					end
					PH_ESC: begin
						if (b == CH_CSI) begin
							do_wait = 1'b1;
							wait_ph = PH_CSI;
						end else if (b == CH_SS3) begin
							do_wait = 1'b1;
							wait_ph = PH_SS3;
						end else begin
							do_emit = 1'b1;
						end
					end
					PH_CSI: begin
						unique case (b) inside
							CH_A: begin
								do_emit  = 1'b1;
								emit_key = KC_UP;
							end
							CH_B: begin
								do_emit  = 1'b1;
								emit_key = KC_DN;
							end
							CH_C: begin
								do_emit  = 1'b1;
								emit_key = KC_RT;
							end
							CH_D: begin
								do_emit  = 1'b1;
								emit_key = KC_LT;
							end
							CH_H: begin
								do_emit  = 1'b1;
								emit_key = KC_HM;
							end
							CH_F: begin
								do_emit  = 1'b1;
								emit_key = KC_END;
							end
							CH_1: begin
								do_wait  = 1'b1;
								wait_ph  = PH_ONE;
								wait_key = KC_HM;
							end
							[CH_2:CH_8]: begin
								do_wait  = 1'b1;
								wait_ph  = PH_DIGIT;
								wait_key = digit_key(3'(b - CH_2));
							end
							default: begin
								do_emit = 1'b1;
							end
						endcase
					end
					PH_SS3: begin
						unique case (b) inside
							CH_H: begin
								do_emit  = 1'b1;
								emit_key = KC_HM;
							end
							CH_F: begin
								do_emit  = 1'b1;
								emit_key = KC_END;
							end
							CH_P, CH_Q, CH_R, CH_S: begin
								do_emit  = 1'b1;
								emit_key = KC_F1 + {3'd0, b[1:0]};
							end
							default: begin
								do_emit = 1'b1;
							end
						endcase
					end
					PH_ONE: begin
						if (b == CH_SEMI) begin
							do_wait  = 1'b1;
							wait_ph  = PH_SEMI;
							wait_key = KC_HM;
						end else begin
							do_emit  = 1'b1;
							emit_key = KC_HM;
						end
					end
					PH_SEMI: begin
						do_wait = 1'b1;
						wait_ph = PH_MOD;
					end
					PH_MOD: begin
						do_emit = 1'b1;
						if (b == CH_H) begin
							emit_key = KC_CHOME;
						end else if (b == CH_F) begin
							emit_key = KC_CEND;
						end
					end
					default: begin
						do_emit  = 1'b1;
						emit_key = pend_q;
					end
				endcase
			end

			if (do_emit) begin
				phase_d = PH_IDLE;
				pend_d  = KC_CHAR;
				cnt_d   = 16'd0;
			end else if (do_wait) begin
				phase_d = wait_ph;
				pend_d  = wait_key;
				cnt_d   = 16'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pend_q  <= KC_CHAR;
			cnt_q   <= 16'd0;
		end else begin
			phase_q <= phase_d;
			pend_q  <= pend_d;
			cnt_q   <= cnt_d;
		end
	end

	assign res_valid      = do_emit;
	assign res.key_code   = emit_key;
	assign res.char_value = emit_char;

endmodule

[rtl/core/akd_obuf.sv]
`timescale 1ns / 1ps

module akd_obuf
	import akd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_data,
	output logic      full
);

	logic      out_valid_q, skid_valid_q;
	out_item_t out_data_q, skid_data_q;
	logic      pop;

	assign pop = out_valid_q & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_data_q <= push_data;
			end else begin
				skid_data_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign full      = skid_valid_q;

endmodule

[tb/sv/akd_key_checker.sv]
`timescale 1ns / 1ps

module akd_key_checker
	import akd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          in_count,
	output int          out_count
);

	phase_t      phase;
	logic [4:0]  held_key;
	logic [15:0] tick_run;
	logic [15:0] gap_ticks;
	out_item_t   expected_keys[$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic emit_key(input logic [4:0] key, input logic [7:0] ch);
		out_item_t item;
		item.key_code = key;
		item.char_value = ch;
		expected_keys.push_back(item);
		phase = PH_IDLE;
		held_key = KC_CHAR;
		tick_run = '0;
	endtask

	task automatic open_phase(input phase_t ph, input logic [4:0] key);
		phase = ph;
		held_key = key;
		tick_run = '0;
	endtask

	function automatic logic [4:0] digit_to_key(input logic [7:0] b);
		logic [4:0] k;
		case (b)
			"2":     k = KC_INS;
			"3":     k = KC_DEL;
			"4":     k = KC_END;
			"5":     k = KC_PAGEU;
			"6":     k = KC_PAGED;
			"7":     k = KC_HM;
			default: k = KC_END;
		endcase
		return k;
	endfunction

	task automatic decode_transfer(input in_item_t it);
		logic [15:0] limit;
		logic [7:0]  b;
		b = it.byte_value;
		if (it.op == OP_TICK) begin
			limit = (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
			if (phase != PH_IDLE) begin
				if (tick_run != 16'hFFFF)
					tick_run++;
				if (tick_run >= limit)
					emit_key(held_key, 8'h00);
			end
		end else begin
			case (phase)
				PH_IDLE: begin
					if (b == CH_ESC)
						open_phase(PH_ESC, KC_ESC);
					else
						emit_key(KC_CHAR, b);
				end
				PH_ESC: begin
					if (b == CH_CSI)
						open_phase(PH_CSI, KC_ESC);
					else if (b == CH_SS3)
						open_phase(PH_SS3, KC_ESC);
					else
						emit_key(KC_ESC, 8'h00);
				end
				PH_CSI: begin
					case (b)
						CH_A:    emit_key(KC_UP, 8'h00);
						CH_B:    emit_key(KC_DN, 8'h00);
						CH_C:    emit_key(KC_RT, 8'h00);
						CH_D:    emit_key(KC_LT, 8'h00);
						CH_H:    emit_key(KC_HM, 8'h00);
						CH_F:    emit_key(KC_END, 8'h00);
						CH_1:    open_phase(PH_ONE, KC_HM);
						default: begin
							if (b >= CH_2 && b <= CH_8)
								open_phase(PH_DIGIT, digit_to_key(b));
							else
								emit_key(KC_ESC, 8'h00);
						end
					endcase
				end
				PH_SS3: begin
					case (b)
						CH_H:                   emit_key(KC_HM, 8'h00);
						CH_F:                   emit_key(KC_END, 8'h00);
						CH_P, CH_Q, CH_R, CH_S: emit_key(KC_F1 + {3'b000, b[1:0]}, 8'h00);
						default:                emit_key(KC_ESC, 8'h00);
					endcase
				end
				PH_ONE: begin
					if (b == CH_SEMI)
						open_phase(PH_SEMI, KC_HM);
					else
						emit_key(KC_HM, 8'h00);
				end
				PH_SEMI: open_phase(PH_MOD, KC_ESC);
				PH_MOD: begin
					if (b == CH_H)
						emit_key(KC_CHOME, 8'h00);
					else if (b == CH_F)
						emit_key(KC_CEND, 8'h00);
					else
						emit_key(KC_ESC, 8'h00);
				end
				default: emit_key(held_key, 8'h00);
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_IDLE;
			held_key = KC_CHAR;
			tick_run = '0;
			gap_ticks = GAP_TICKS_RESET;
			expected_keys.delete();
			pending = 0;
			fail_count = 0;
			in_count = 0;
			out_count = 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_GAP_TICKS) begin
				if (pwrite)
					gap_ticks = pwdata[15:0];
				else if (prdata[15:0] !== gap_ticks)
					report_mismatch("gap_ticks readback", prdata, {16'h0000, gap_ticks});
			end
			if (in_valid && !in_stall) begin
				decode_transfer(in_data);
				in_count++;
			end
			if (out_valid && !out_stall) begin
				out_item_t want;
				out_count++;
				if (expected_keys.size() == 0) begin
					report_mismatch("key event with none expected", {19'h0, out_data}, 32'h0);
				end else begin
					want = expected_keys.pop_front();
					if (out_data.key_code !== want.key_code)
						report_mismatch("key_code", 32'(out_data.key_code),
								32'(want.key_code));
					if (out_data.char_value !== want.char_value)
						report_mismatch("char_value", 32'(out_data.char_value),
								32'(want.char_value));
				end
			end
			pending = expected_keys.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
	import akd_pkg::*;
();

	localparam logic [2:0] ADDR_GAP_TICKS = {REG_GAP_TICKS, 2'b00};
	localparam logic [2:0] ADDR_UNUSED = 3'd4;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int in_count;
	int out_count;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int byte_count = 0;
	int gap_now = 50;

	ansi_key_escape_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	akd_key_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.in_count   (in_count),
		.out_count  (out_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL ansi_key_escape_decoder");
			$finish;
		end
	end

	// A long hold-off takes priority over the random stall pattern.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	task automatic send_item(input logic op, input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.op = op;
		in_data.byte_value = b;
		do @(posedge clk); while (in_stall);
		if (op == OP_BYTE)
			byte_count++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_item(OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic maybe_ticks;
		if ($urandom_range(9) == 0)
			send_ticks($urandom_range(gap_now, 1));
	endtask

	task automatic drain;
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = addr;
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic set_gap(input logic [15:0] value);
		drain();
		apb_access(1'b1, ADDR_GAP_TICKS, {16'($urandom), value});
		apb_access(1'b0, ADDR_GAP_TICKS, 32'h0);
		gap_now = (value == 16'd0) ? 1 : int'(value);
	endtask

	task automatic random_sequence;
		int kind;
		int sub;
		kind = $urandom_range(99);
		sub = $urandom_range(99);
		if (kind < 15) begin
			send_item(OP_BYTE, 8'($urandom_range(255)));
		end else if (kind < 25) begin
			send_item(OP_BYTE, CH_ESC);
			send_ticks(gap_now);
		end else if (kind < 45) begin
			send_item(OP_BYTE, CH_ESC);
			maybe_ticks();
			send_item(OP_BYTE, CH_CSI);
			maybe_ticks();
			case ($urandom_range(5))
				0:       send_item(OP_BYTE, CH_A);
				1:       send_item(OP_BYTE, CH_B);
				2:       send_item(OP_BYTE, CH_C);
				3:       send_item(OP_BYTE, CH_D);
				4:       send_item(OP_BYTE, CH_H);
				default: send_item(OP_BYTE, CH_F);
			endcase
		end else if (kind < 60) begin
			send_item(OP_BYTE, CH_ESC);
			send_item(OP_BYTE, CH_CSI);
			maybe_ticks();
			send_item(OP_BYTE, 8'($urandom_range(CH_8, CH_2)));
			if (sub < 70)
				send_item(OP_BYTE, "~");
			else if (sub < 90)
				send_item(OP_BYTE, 8'($urandom_range(255)));
			else
				send_ticks(gap_now);
		end else if (kind < 72) begin
			send_item(OP_BYTE, CH_ESC);
			send_item(OP_BYTE, CH_CSI);
			send_item(OP_BYTE, CH_1);
			maybe_ticks();
			if (sub < 60) begin
				send_item(OP_BYTE, CH_SEMI);
				send_item(OP_BYTE, 8'($urandom_range(255)));
				maybe_ticks();
				case ($urandom_range(3))
					0, 1:    send_item(OP_BYTE, CH_H);
					2:       send_item(OP_BYTE, CH_F);
					default: send_item(OP_BYTE, 8'($urandom_range(255)));
				endcase
			end else if (sub < 80) begin
				send_item(OP_BYTE, 8'($urandom_range(255)));
			end else begin
				if (sub < 90)
					send_item(OP_BYTE, CH_SEMI);
				send_ticks(gap_now);
			end
		end else if (kind < 87) begin
			send_item(OP_BYTE, CH_ESC);
			send_item(OP_BYTE, CH_SS3);
			maybe_ticks();
			case ($urandom_range(6))
				0:       send_item(OP_BYTE, CH_H);
				1:       send_item(OP_BYTE, CH_F);
				2:       send_item(OP_BYTE, CH_P);
				3:       send_item(OP_BYTE, CH_Q);
				4:       send_item(OP_BYTE, CH_R);
				5:       send_item(OP_BYTE, CH_S);
				default: send_item(OP_BYTE, 8'($urandom_range(255)));
			endcase
		end else begin
			if (sub < 40) begin
				send_item(OP_BYTE, 8'($urandom_range(255)));
			end else if (sub < 70) begin
				send_ticks($urandom_range(3));
			end else begin
				send_item(OP_BYTE, CH_ESC);
				send_item(OP_BYTE, 8'($urandom_range(255)));
			end
		end
	endtask

	task automatic random_phase(input int idle, input int stall, input int n_bytes);
		int target;
		idle_pct = idle;
		stall_pct = stall;
		target = byte_count + n_bytes;
		while (byte_count < target) random_sequence();
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		apb_access(1'b0, ADDR_GAP_TICKS, 32'h0);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, CH_A);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_SS3);
		send_item(OP_BYTE, CH_P);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, CH_1);
		send_item(OP_BYTE, CH_SEMI);
		send_item(OP_BYTE, "5");
		send_item(OP_BYTE, CH_H);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, "3");
		send_item(OP_BYTE, "~");
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, CH_1);
		send_item(OP_BYTE, "x");

		// A zero gap acts as one, so each single tick below ends its sequence.
		set_gap(16'd0);
		send_item(OP_BYTE, CH_ESC);
		send_ticks(1);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, CH_1);
		send_item(OP_BYTE, CH_SEMI);
		send_ticks(1);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, "5");
		send_ticks(1);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_CSI);
		send_item(OP_BYTE, CH_1);
		send_item(OP_BYTE, CH_SEMI);
		send_item(OP_BYTE, "5");
		send_ticks(1);

		set_gap(16'd1);
		send_item(OP_BYTE, CH_ESC);
		send_item(OP_BYTE, CH_SS3);
		send_ticks(1);
		drain();
		apb_access(1'b1, ADDR_UNUSED, $urandom);
		apb_access(1'b0, ADDR_GAP_TICKS, 32'h0);

		set_gap(16'hFFFF);
		send_item(OP_BYTE, CH_ESC);
		send_ticks(20);
		send_item(OP_BYTE, "x");

		set_gap(16'd2);
		@(posedge clk);
		hold_left = 300;
		random_phase(0, 0, 230);
		set_gap(16'd0);
		random_phase(73, 0, 230);
		set_gap(16'($urandom_range(8, 3)));
		random_phase(0, 73, 230);
		set_gap(16'd1);
		random_phase(36, 36, 230);

		drain();
		repeat (10) @(negedge clk);
		$display("Checked %0d input transfers and %0d key events.", in_count, out_count);
		$display("Gap settings 0, 1, 2, 50, 65535 and one random value; four flow-control mixes.");
		if (fail_count == 0) begin
			$display("PASS ansi_key_escape_decoder");
		end else begin
			$display("FAIL ansi_key_escape_decoder");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/akd_pkg.sv
rtl/core/akd_apb.sv
rtl/core/akd_decode.sv
rtl/core/akd_obuf.sv
rtl/core/ansi_key_escape_decoder.sv
tb/sv/akd_key_checker.sv
tb/sv/tb_top.sv
